// ----- src/bmap_pkg.sv -----
// Shared types and constants for the banked-window bus decoder.
// No dependencies; imported by every module of the block.
package bmap_pkg;

    localparam int unsigned RAM_BYTES_DEF = 8192;
    localparam int unsigned BANK_BITS_DEF = 9;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam int unsigned ADDR_W = 24;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned WIN_W  = 15;

    // external request kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SREG    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TONE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_VIDEO   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BUS_RD  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BUS_WR  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd6;

    // sound-side map boundaries
    localparam logic [15:0] SND_SREG_BASE = 16'h4000;
    localparam logic [15:0] SND_BANK_BASE = 16'h6000;
    localparam logic [15:0] SND_TONE_BASE = 16'h6100;
    localparam logic [15:0] SND_WIN_BASE  = 16'h8000;
    localparam logic [7:0]  SND_TONE_LOW  = 8'h11;
    localparam logic [7:0]  READ_FF       = 8'hFF;

    // main-side map
    localparam logic [ADDR_W-1:0] VIDEO_BASE     = 24'hC00000;
    localparam logic [ADDR_W-1:0] HOST_RAM_BASE  = 24'hA00000;
    localparam logic [ADDR_W-1:0] HOST_SREG_BASE = 24'hA04000;
    localparam logic [ADDR_W-1:0] HOST_BANK_BASE = 24'hA06000;
    localparam logic [ADDR_W-1:0] HOST_BANK_END  = 24'hA06100;
    localparam logic [ADDR_W-1:0] HOST_AREA_END  = 24'hA10000;
    localparam logic [ADDR_W-1:0] BUSREQ_ADDR    = 24'hA11100;
    localparam logic [ADDR_W-1:0] RESET_ADDR     = 24'hA11200;

    typedef enum logic [3:0] {
        OP_CONST,
        OP_RAM_RD,
        OP_RAM_WR,
        OP_EXT,
        OP_BANK_SHIFT,
        OP_BANKED,
        OP_BUSREQ_RD,
        OP_BUSREQ_WR,
        OP_RESET_WR
    } op_t;

    // decoded request; data is the fixed read byte, the write byte or the ext byte
    typedef struct packed {
        op_t               op;
        logic              handled;
        logic              word;
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              handled;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] ext_address;
        logic [BYTE_W-1:0] ext_data;
        logic              runnable;
    } res_t;

    typedef struct packed {
        logic clearing;
        logic bus_requested;
        logic reset_held;
    } status_t;

endpackage

// ----- src/bmap_front.sv -----
// Front end: accepts a bus request and classifies it into a command.
// Depends on bmap_pkg.
module bmap_front
    import bmap_pkg::*;
#(
    parameter int unsigned RAM_BYTES = RAM_BYTES_DEF
)
(
    input  logic              side,
    input  logic              opcode,
    input  logic              word_access,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    output cmd_t              cmd
);

    logic [13:0]       rem;
    logic [15:0]       a;
    logic [BYTE_W-1:0] v;
    logic              in_ram;
    logic              in_sreg;
    logic              in_bank;
    logic              in_area;
    logic              is_busreq;
    logic              is_reset;

    // RAM index: window offset mod RAM_BYTES, quotient fits in four bits
    always_comb
    begin
        rem = address[13:0];
        for (int k = 3; k >= 0; k--)
        begin
            if ({6'b0, rem} >= (20'(RAM_BYTES) << k))
            begin
                rem = rem - 14'(RAM_BYTES << k);
            end
        end
    end

    assign a = address[15:0];
    assign v = (side && word_access) ? write_data[15:8] : write_data[7:0];

    assign in_ram    = (address >= HOST_RAM_BASE) && (address < HOST_SREG_BASE);
    assign in_sreg   = (address >= HOST_SREG_BASE) && (address < HOST_BANK_BASE);
    assign in_bank   = (address >= HOST_BANK_BASE) && (address < HOST_BANK_END);
    assign in_area   = (address >= HOST_RAM_BASE) && (address < HOST_AREA_END);
    assign is_busreq = (address[ADDR_W-1:1] == BUSREQ_ADDR[ADDR_W-1:1]);
    assign is_reset  = (address[ADDR_W-1:1] == RESET_ADDR[ADDR_W-1:1]);

    always_comb
    begin
        cmd.op      = OP_CONST;
        cmd.handled = 1'b0;
        cmd.word    = 1'b0;
        cmd.data    = '0;
        cmd.kind    = KIND_NONE;
        cmd.addr    = '0;
        if (!side)
        begin
            cmd.handled = 1'b1;
            priority if (a < SND_SREG_BASE)
            begin
                cmd.op   = opcode ? OP_RAM_WR : OP_RAM_RD;
                cmd.addr = ADDR_W'(rem);
                cmd.data = v;
            end
            else if (a < SND_BANK_BASE)
            begin
                if (opcode)
                begin
                    cmd.op   = OP_EXT;
                    cmd.kind = KIND_SREG;
                    cmd.addr = {22'b0, a[1:0]};
                    cmd.data = v;
                end
            end
            else if (a < SND_WIN_BASE)
            begin
                priority if (!opcode)
                begin
                    cmd.data = READ_FF;
                end
                else if (a < SND_TONE_BASE)
                begin
                    cmd.op   = OP_BANK_SHIFT;
                    cmd.data = v;
                end
                else if (a[7:0] == SND_TONE_LOW)
                begin
                    cmd.op   = OP_EXT;
                    cmd.kind = KIND_TONE;
                    cmd.data = v;
                end
                else
                begin
                    cmd.op   = OP_EXT;
                    cmd.kind = KIND_VIDEO;
                    cmd.addr = VIDEO_BASE | {19'b0, a[4:0]};
                    cmd.data = v;
                end
            end
            else
            begin
                cmd.op   = OP_BANKED;
                cmd.addr = {9'b0, a[WIN_W-1:0]};
                cmd.kind = opcode ? KIND_BUS_WR : KIND_BUS_RD;
                cmd.data = opcode ? v : 8'h00;
            end
        end
        else if (!opcode)
        begin
            cmd.word = word_access;
            priority if (in_ram)
            begin
                cmd.op      = OP_RAM_RD;
                cmd.addr    = ADDR_W'(rem);
                cmd.handled = 1'b1;
            end
            else if (in_sreg)
            begin
                cmd.handled = 1'b1;
            end
            else if (is_busreq)
            begin
                cmd.op      = address[0] ? OP_CONST : OP_BUSREQ_RD;
                cmd.handled = 1'b1;
            end
            else if (is_reset)
            begin
                cmd.handled = 1'b1;
            end
        end
        else
        begin
            priority if (in_ram)
            begin
                cmd.op      = OP_RAM_WR;
                cmd.addr    = ADDR_W'(rem);
                cmd.data    = v;
                cmd.handled = 1'b1;
            end
            else if (in_sreg)
            begin
                cmd.op      = OP_EXT;
                cmd.kind    = KIND_SREG;
                cmd.addr    = {22'b0, address[1:0]};
                cmd.data    = v;
                cmd.handled = 1'b1;
            end
            else if (in_bank)
            begin
                cmd.op      = OP_BANK_SHIFT;
                cmd.data    = v;
                cmd.handled = 1'b1;
            end
            else if (in_area)
            begin
                cmd.handled = 1'b1;
            end
            else if (is_busreq)
            begin
                cmd.op      = address[0] ? OP_CONST : OP_BUSREQ_WR;
                cmd.data    = address[0] ? 8'h00 : v;
                cmd.handled = 1'b1;
            end
            else if (is_reset)
            begin
                cmd.op      = address[0] ? OP_CONST : OP_RESET_WR;
                cmd.data    = address[0] ? 8'h00 : v;
                cmd.handled = 1'b1;
            end
        end
    end

endmodule

// ----- src/bmap_queue.sv -----
// Short command queue between the decode front end and the execute back end.
// Depends on bmap_pkg.
module bmap_queue
    import bmap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/bmap_back.sv -----
// Back end: executes commands against the local RAM, bank register and flags,
// and holds the result register. Depends on bmap_pkg.
module bmap_back
    import bmap_pkg::*;
#(
    parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
    parameter int unsigned BANK_BITS = BANK_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output res_t    res,
    output status_t status
);

    localparam int unsigned RAM_AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_BYTES - 1);

    logic [BYTE_W-1:0]    ram_mem [RAM_BYTES];
    logic [BYTE_W-1:0]    ram_rdata_reg;
    logic                 ram_we;
    logic                 ram_re;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;

    logic                 clr_busy_reg;
    logic [RAM_AW-1:0]    clr_idx_reg;

    logic [BANK_BITS-1:0] bank_reg;
    logic [BANK_BITS-1:0] bank_next;
    logic                 busreq_reg;
    logic                 busreq_next;
    logic                 held_reg;
    logic                 held_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_W-1:0]    byte_reg;
    logic [BYTE_W-1:0]    byte_next;
    logic                 use_ram_reg;
    logic                 word_reg;
    logic                 handled_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [KIND_W-1:0]    kind_next;
    logic [ADDR_W-1:0]    eaddr_reg;
    logic [ADDR_W-1:0]    eaddr_next;
    logic [BYTE_W-1:0]    edata_reg;
    logic [BYTE_W-1:0]    edata_next;
    logic                 runnable_reg;

    logic                 exec;
    logic [BYTE_W-1:0]    rd_byte;

    assign exec    = cmd_valid && !clr_busy_reg && (!out_valid_reg || res_ready);
    assign cmd_pop = exec;

    // state update and result fields of the command at the queue head
    always_comb
    begin
        bank_next   = bank_reg;
        busreq_next = busreq_reg;
        held_next   = held_reg;
        byte_next   = 8'h00;
        kind_next   = KIND_NONE;
        eaddr_next  = '0;
        edata_next  = 8'h00;
        unique case (cmd.op)
            OP_CONST:
            begin
                byte_next = cmd.data;
            end
            OP_RAM_RD, OP_RAM_WR:
            begin
            end
            OP_EXT:
            begin
                kind_next  = cmd.kind;
                eaddr_next = cmd.addr;
                edata_next = cmd.data;
            end
            OP_BANK_SHIFT:
            begin
                bank_next = BANK_BITS'({cmd.data[0], bank_reg} >> 1);
            end
            OP_BANKED:
            begin
                kind_next  = cmd.kind;
                eaddr_next = ADDR_W'({bank_reg, cmd.addr[WIN_W-1:0]});
                edata_next = cmd.data;
            end
            OP_BUSREQ_RD:
            begin
                byte_next = {7'b0, !busreq_reg};
            end
            OP_BUSREQ_WR:
            begin
                busreq_next = cmd.data[0];
            end
            OP_RESET_WR:
            begin
                held_next = !cmd.data[0];
                if (cmd.data[0] && held_reg)
                begin
                    kind_next = KIND_RESTART;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // RAM port: clearing pass first, then at most one access per executed command
    assign ram_we    = clr_busy_reg || (exec && (cmd.op == OP_RAM_WR));
    assign ram_re    = exec && (cmd.op == OP_RAM_RD);
    assign ram_waddr = clr_busy_reg ? clr_idx_reg : cmd.addr[RAM_AW-1:0];
    assign ram_wdata = clr_busy_reg ? 8'h00 : cmd.data;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            ram_rdata_reg <= ram_mem[cmd.addr[RAM_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            bank_reg      <= '0;
            busreq_reg    <= 1'b1;
            held_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == RAM_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (exec)
            begin
                bank_reg   <= bank_next;
                busreq_reg <= busreq_next;
                held_reg   <= held_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            byte_reg     <= byte_next;
            use_ram_reg  <= (cmd.op == OP_RAM_RD);
            word_reg     <= cmd.word;
            handled_reg  <= cmd.handled;
            kind_reg     <= kind_next;
            eaddr_reg    <= eaddr_next;
            edata_reg    <= edata_next;
            runnable_reg <= !busreq_next && !held_next;
        end
    end

    assign rd_byte = use_ram_reg ? ram_rdata_reg : byte_reg;

    assign res_valid       = out_valid_reg;
    assign res.read_data   = word_reg ? {rd_byte, rd_byte} : {8'h00, rd_byte};
    assign res.handled     = handled_reg;
    assign res.kind        = kind_reg;
    assign res.ext_address = eaddr_reg;
    assign res.ext_data    = edata_reg;
    assign res.runnable    = runnable_reg;

    assign status.clearing      = clr_busy_reg;
    assign status.bus_requested = busreq_reg;
    assign status.reset_held    = held_reg;

endmodule

// ----- src/coprocessor_bus_map_arbiter.sv -----
// Top level of the banked-window bus decoder for the sound coprocessor.
// Depends on bmap_pkg, bmap_front, bmap_queue and bmap_back.
//
// Each request is one byte or word access from the sound CPU bus (16-bit address)
// or the main CPU bus (24-bit address). The front end decodes the address map and
// pushes a command into a two-entry queue; the back end executes it against the
// local RAM, the bank register and the bus-request and reset-held flags, and
// leaves one result per request in an output register. Throughput is one request
// per clock while results are taken; the back end uses its single RAM port at most
// once per command; a result passes through the queue and then the output register,
// and the queue lets the input keep flowing while a result waits. After reset the
// RAM is zeroed by a clearing pass over its RAM_BYTES bytes (8192 by default),
// during which s_tready is low. Results with ext_kind other than none describe a
// request for an external unit (sound register, tone chip, video chip, banked main
// bus, restart pulse); the caller carries those out, this block only reports them.
module coprocessor_bus_map_arbiter
    import bmap_pkg::*;
#(
    parameter int unsigned RAM_BYTES = RAM_BYTES_DEF,
    parameter int unsigned BANK_BITS = BANK_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[23:0], write_data[39:24]
    input  logic [2:0]  s_tuser,   // side[0], opcode[1], word_access[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // read_data[15:0], handled[16], ext_address[40:17],
                                   // ext_data[48:41], runnable[49], zero[55:50]
    output logic [2:0]  m_tuser    // ext_kind[2:0]
);

    localparam int unsigned RUN_BIT = 49;

    cmd_t    dec_cmd;
    cmd_t    head_cmd;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    accept;
    res_t    res;
    status_t status;

    // no request while the RAM is being cleared or the queue is full
    assign s_tready = !q_full && !status.clearing;
    assign accept   = s_tvalid && s_tready;

    bmap_front #(
        .RAM_BYTES (RAM_BYTES)
    ) u_front (
        .side        (s_tuser[0]),
        .opcode      (s_tuser[1]),
        .word_access (s_tuser[2]),
        .address     (s_tdata[23:0]),
        .write_data  (s_tdata[39:24]),
        .cmd         (dec_cmd)
    );

    bmap_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (dec_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    bmap_back #(
        .RAM_BYTES (RAM_BYTES),
        .BANK_BITS (BANK_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .status    (status)
    );

    assign m_tdata = {6'b0, res.runnable, res.ext_data, res.ext_address,
                      res.handled, res.read_data};
    assign m_tuser = res.kind;

    // nothing is taken in while the RAM clearing pass runs
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.clearing |-> !s_tready
    ) else $error("request accepted during RAM clearing pass");

    // the back end stalls while a result waits, so the flags match the shown result
    a_runnable_matches_flags: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RUN_BIT] == (!status.bus_requested && !status.reset_held))
    ) else $error("runnable disagrees with bus and reset flags");

    // a restart pulse is reported only once reset has been released
    a_restart_releases_reset: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_RESTART)) |-> !status.reset_held
    ) else $error("restart reported while reset still held");

    // the queue is never popped while the clearing pass owns the RAM
    a_no_exec_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.clearing |=> !m_tvalid || $past(m_tvalid)
    ) else $error("result produced during RAM clearing pass");

endmodule
